>>> rtl/mccd_pkg.sv
// ----------------------------------------------------------------------------
// mccd_pkg
// Shared types and constants for the minimum stamp count block.
// ----------------------------------------------------------------------------
package mccd_pkg;

  // field widths
  localparam int AMT_W   = 10;
  localparam int DENOM_W = 10;
  localparam int CNT_W   = 3;
  localparam int COST_W  = 11;
  localparam int AMT_MAX = (1 << AMT_W) - 1;

  // bus widths, padded to whole bytes
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;

  // configuration register file
  localparam int NUM_DENOM_REGS = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DENOM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DENOM_A     = 3'd1;

  // parameter defaults
  localparam int DEF_MAX_REQUEST = 1023;
  localparam int DEF_MAX_DENOMS  = 7;

  // cost table marker for an unreachable amount
  localparam logic [COST_W-1:0] COST_NONE = '1;

  localparam logic [CNT_W-1:0] DENOM_COUNT_RESET = 3'd7;

  typedef logic [DENOM_W-1:0] denom_t;
  typedef logic [COST_W-1:0]  cost_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_FILL,
    ST_DONE
  } state_t;

  // reset value of each denomination register
  function automatic denom_t denom_reset(input logic [CNT_W-1:0] idx);
    denom_t val;
    unique case (idx)
      3'd0:    val = 10'd1;
      3'd1:    val = 10'd2;
      3'd2:    val = 10'd6;
      3'd3:    val = 10'd10;
      3'd4:    val = 10'd24;
      3'd5:    val = 10'd30;
      3'd6:    val = 10'd90;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/mccd_ram.sv
// ----------------------------------------------------------------------------
// mccd_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mccd_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/min_coin_change_dp.sv
// ----------------------------------------------------------------------------
// min_coin_change_dp
// Fewest stamps that add up exactly to a requested amount (coin change).
// ----------------------------------------------------------------------------
// A request word on the s_ channel carries an amount. The block fills a cost
// table in RAM for every amount from 1 up to the request, each entry the
// minimum over usable denominations of cost[amount - denom] + 1, and returns
// one result word on the m_ channel: min_stamps in m_tdata, and m_tuser high
// when the amount cannot be reached (min_stamps is then 0).
// Denominations are written through cfg_we / cfg_addr / cfg_wdata; the user
// must write them only while idle, as the block does not enforce it. Index 0
// is the count in use, indexes 1..7 the stamp values (0 = unused). Each amount
// is worked in steps set by the single RAM read port: one table read step per
// denomination in use (nd), then a write-back step. One request is worked at
// a time. The result sits in an output register; a new request is taken as
// soon as that register is loaded, and if the receiver stalls with a result
// still pending, the next result waits in the sequencer until it is taken.
// Reset: synchronous, restores the default denominations (1, 2, 6, 10, 24,
// 30, 90, count 7); the table needs no clearing since each request writes
// every entry before it reads it.
// ----------------------------------------------------------------------------
module min_coin_change_dp #(
  parameter int MAX_REQUEST = mccd_pkg::DEF_MAX_REQUEST,
  parameter int MAX_DENOMS  = mccd_pkg::DEF_MAX_DENOMS
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [mccd_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [mccd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mccd_pkg::S_DATA_W-1:0]      s_tdata,  // [9:0] request_amount
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mccd_pkg::M_DATA_W-1:0]      m_tdata,  // [9:0] min_stamps
  output logic                               m_tuser   // [0] unreachable
);

  import mccd_pkg::*;

  // table sized to the smaller of MAX_REQUEST and the largest request the input field can carry
  localparam bit LIMIT_CUT = MAX_REQUEST < AMT_MAX;
  localparam int TABLE_DEPTH = LIMIT_CUT ? MAX_REQUEST + 1 : AMT_MAX + 1;
  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam logic [AMT_W-1:0] REQ_LIMIT = AMT_W'(LIMIT_CUT ? MAX_REQUEST : AMT_MAX);
  localparam logic [CNT_W-1:0] DENOM_CAP =
    CNT_W'((MAX_DENOMS < NUM_DENOM_REGS) ? MAX_DENOMS : NUM_DENOM_REGS);

  state_t state, state_next;

  logic [CNT_W-1:0] denom_count;
  denom_t           denom_regs [NUM_DENOM_REGS];

  logic [AMT_W-1:0] req;
  logic [AMT_W-1:0] amt;
  logic [CNT_W-1:0] didx;
  logic [CNT_W-1:0] nd;
  cost_t            best;
  logic             pend;

  logic             s_fire;
  logic             req_over;
  logic             issue;
  logic             last_denom;
  denom_t           dsel;
  logic             usable;
  cost_t            rdata;
  cost_t            cand;
  logic             take;
  cost_t            best_fin;

  logic             ram_we;
  logic [TAW-1:0]   ram_waddr;
  cost_t            ram_wdata;
  logic             ram_re;
  logic [TAW-1:0]   ram_raddr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      denom_count <= DENOM_COUNT_RESET;
      for (int i = 0; i < NUM_DENOM_REGS; i++) begin
        denom_regs[i] <= denom_reset(CNT_W'(i));
      end
    end else if (cfg_we) begin
      if (cfg_addr == REG_DENOM_COUNT) begin
        denom_count <= cfg_wdata[CNT_W-1:0];
      end else begin
        denom_regs[CNT_W'(cfg_addr - REG_DENOM_A)] <= cfg_wdata[DENOM_W-1:0];
      end
    end
  end

  // denominations in use, clamped to the limit
  assign nd = (denom_count > DENOM_CAP) ? DENOM_CAP : denom_count;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign req_over = s_tdata[AMT_W-1:0] > REQ_LIMIT;

  // current denomination and its sub-amount lookup
  assign last_denom = (didx >= nd);
  assign dsel       = (didx < CNT_W'(NUM_DENOM_REGS)) ? denom_regs[didx] : '0;
  assign usable     = (dsel != '0) && (dsel <= amt);

  // fold the data of the read issued last cycle into the running minimum
  assign cand     = rdata + cost_t'(1);
  assign take     = pend && (rdata != COST_NONE) && (cand < best);
  assign best_fin = take ? cand : best;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          state_next = req_over ? ST_DONE : ST_INIT;
        end
      end
      ST_INIT: begin
        state_next = (req == '0) ? ST_DONE : ST_FILL;
      end
      ST_FILL: begin
        if (last_denom && (amt == req)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    issue     = 1'b0;
    unique case (state)
      ST_INIT: begin
        ram_we = 1'b1;
      end
      ST_FILL: begin
        if (last_denom) begin
          ram_we    = 1'b1;
          ram_waddr = TAW'(amt);
          ram_wdata = best_fin;
        end else begin
          issue = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign ram_re    = issue && usable;
  assign ram_raddr = TAW'(amt - dsel);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // amount / denomination counters and running minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      amt  <= '0;
      didx <= '0;
      best <= COST_NONE;
      pend <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          pend <= 1'b0;
          if (s_fire) begin
            best <= COST_NONE;
          end
        end
        ST_INIT: begin
          amt  <= AMT_W'(1);
          didx <= '0;
          best <= (req == '0) ? '0 : COST_NONE;
        end
        ST_FILL: begin
          if (last_denom) begin
            pend <= 1'b0;
            if (amt == req) begin
              best <= best_fin;
            end else begin
              amt  <= amt + AMT_W'(1);
              didx <= '0;
              best <= COST_NONE;
            end
          end else begin
            pend <= usable;
            didx <= didx + CNT_W'(1);
            best <= best_fin;
          end
        end
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_fire) begin
      req <= s_tdata[AMT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tuser <= (best == COST_NONE);
      m_tdata <= (best == COST_NONE) ? '0 : M_DATA_W'(best[AMT_W-1:0]);
    end
  end

  // cost table
  mccd_ram #(
    .WIDTH (COST_W),
    .DEPTH (TABLE_DEPTH)
  ) u_cost_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // checks
  a_we_in_fill: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_INIT || state == ST_FILL))
    else $error("cost table written outside fill");

  a_pend_follows_read: assert property (@(posedge clk) disable iff (rst)
    pend |-> ($past(ram_re) && $past(state) == ST_FILL))
    else $error("pending compare without a table read");

  a_amt_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (amt != '0 && amt <= req))
    else $error("amount index out of range");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("unreachable result with nonzero count");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> (state != ST_IDLE))
    else $error("request accepted without starting work");

endmodule
